// File: design/cki_pkg.sv
package cki_pkg;

  localparam int PHASE_W = 16;
  localparam int ANGLE_W = 16;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_TICK  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ANGLE  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_JOINTS_LEFT  = 2'd0,
    CFG_JOINTS_RIGHT = 2'd1,
    CFG_WALK_SPEED   = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               side;
    logic [15:0]        key_time;
    logic [2:0]         joint_index;
    logic signed [15:0] key_angle;
    logic               last_of_key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               out_side;
    logic [2:0]         out_joint;
    logic signed [15:0] angle;
    logic               in_segment;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIDE,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_SCAN_C,
    ST_JOINT,
    ST_RD_A,
    ST_RD_B,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: design/cki_ram.sv
module cki_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/cyclic_keyframe_interpolator.sv
// Keyframe interpolator for two limbs. Keys arrive one joint angle per transfer
// and are written straight into the side's time and angle RAMs; the final
// element returns one accept/reject status. A tick (or a query, which leaves
// the phase alone) walks each side's key table one key at a time through the
// scan states ST_SCAN_A, ST_SCAN_B and ST_SCAN_C to find the segment holding
// the phase, then for every joint reads two angles, multiplies, and runs a
// restoring divider one quotient bit per cycle. Output stalls hold the walk;
// the block takes no new item until all results have transferred.
module cyclic_keyframe_interpolator
  import cki_pkg::*;
#(
  parameter int MAX_KEYS   = 16,
  parameter int MAX_JOINTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int JW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int TW  = $clog2(MAX_KEYS + 1);
  localparam int TA  = KW + 1;
  localparam int AA  = KW + JW + 1;
  localparam int TD  = 1 << TA;
  localparam int AD  = 1 << AA;
  localparam int DW  = 17;
  localparam int PW  = 34;
  localparam logic [4:0] JMAX = 5'(MAX_JOINTS);

  state_t state_r, state_nxt;

  logic [3:0]  jcl_r, jcr_r;
  logic [15:0] speed_r, phase_r;
  logic [TW-1:0] total_r [2];
  logic [3:0]  pend_r;

  logic     side_r;
  logic [TW-1:0] ki_r;
  logic [15:0] ta_r;
  logic        found_r;
  logic [KW-1:0] seg_r, nxt_r;
  logic [DW-1:0] dp_r, dt_r;
  logic [4:0]  j_r;
  logic signed [16:0] a_r, diff_r;
  logic [PW-1:0] num_r;
  logic        neg_r;
  logic [PW-1:0] quo_r;
  logic [DW:0] rem_r;
  logic [5:0]  bit_r;
  out_item_t   res_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE) && !out_valid;

  logic in_fire, out_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // joint counts clamped
  function automatic logic [4:0] clampj(input logic [3:0] c);
    logic [4:0] e;
    e = {1'b0, c};
    return (e > JMAX) ? JMAX : e;
  endfunction

  logic [4:0] nj_side;
  assign nj_side = clampj(side_r ? jcr_r : jcl_r);

  // key element path
  logic [TW-1:0] slot;
  logic          room;
  logic [3:0]    pend_inc;
  logic          key_ok;
  assign slot     = total_r[in_data.side];
  assign room     = slot < TW'(MAX_KEYS);
  assign pend_inc = (pend_r < 4'd15) ? pend_r + 4'd1 : pend_r;
  assign key_ok   = room && ({1'b0, pend_inc} == clampj(in_data.side ? jcr_r : jcl_r));

  logic key_in;
  assign key_in = in_fire && (in_data.opcode == OP_KEY);

  // rams
  logic [TA-1:0] t_waddr, t_raddr;
  logic [15:0]   t_rdata;
  logic [AA-1:0] a_waddr, a_raddr;
  logic [15:0]   a_rdata;
  logic [KW-1:0] slot_k, rd_key, ki_next;
  logic          a_we;

  assign slot_k  = slot[KW-1:0];
  assign ki_next = KW'(ki_r + TW'(1));
  assign t_waddr = {in_data.side, slot_k};
  assign a_waddr = {in_data.side, slot_k, JW'(in_data.joint_index)};
  assign a_we    = key_in && room &&
                   ({2'b00, in_data.joint_index} < 5'(MAX_JOINTS));
  // start time of the key in the first scan cycle, end time in the second
  assign t_raddr = {side_r, (state_r == ST_SCAN_B) ? ki_next : ki_r[KW-1:0]};
  assign rd_key  = (state_r == ST_RD_A) ? seg_r : nxt_r;
  assign a_raddr = {side_r, rd_key, j_r[JW-1:0]};

  cki_ram #(.WIDTH(16), .DEPTH(TD)) u_times (
    .clk(clk), .we(key_in && room), .waddr(t_waddr), .wdata(in_data.key_time),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  cki_ram #(.WIDTH(16), .DEPTH(AD)) u_angles (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(in_data.key_angle),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  // segment test: end bound is the next key's time, or 0x10000 for the last key
  logic [DW-1:0] tb_w;
  logic          last_key;
  assign last_key = (ki_r + TW'(1)) >= total_r[side_r];
  assign tb_w     = last_key ? 17'h10000 : {1'b0, t_rdata};

  // divider step
  logic [DW:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_r[DW-1:0], num_r[PW-1]};
  assign rem_ge = rem_sh >= {1'b0, dt_r};

  // final value with saturation
  logic signed [PW:0] qs;
  logic signed [PW:0] vsum;
  logic signed [15:0] vsat;
  assign qs   = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign vsum = qs + (PW+1)'(a_r);
  assign vsat = (vsum > 35'sd32767) ? 16'sh7fff :
                (vsum < -35'sd32768) ? 16'sh8000 : vsum[15:0];

  logic more_joints;
  assign more_joints = (j_r + 5'd1) < nj_side;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.opcode == OP_TICK || in_data.opcode == OP_QUERY)) begin
          state_nxt = ST_SIDE;
        end
      end
      ST_SIDE: begin
        if (nj_side == 5'd0) begin
          state_nxt = side_r ? ST_IDLE : ST_SIDE;
        end else if (total_r[side_r] == '0) begin
          state_nxt = ST_JOINT;
        end else begin
          state_nxt = ST_SCAN_A;
        end
      end
      ST_SCAN_A: state_nxt = ST_SCAN_B;
      ST_SCAN_B: state_nxt = ST_SCAN_C;
      ST_SCAN_C: state_nxt = last_key ? ST_JOINT : ST_SCAN_A;
      ST_JOINT:  state_nxt = found_r ? ST_RD_A : ST_OUT;
      ST_RD_A:   state_nxt = ST_RD_B;
      ST_RD_B:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_DIV;
      ST_DIV:    state_nxt = (bit_r == 6'd0) ? ST_OUT : ST_DIV;
      ST_OUT: begin
        if (!out_valid) begin
          if (more_joints) begin
            state_nxt = ST_JOINT;
          end else begin
            state_nxt = side_r ? ST_IDLE : ST_SIDE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_data = res_r;

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      jcl_r      <= '0;
      jcr_r      <= '0;
      speed_r    <= '0;
      phase_r    <= '0;
      total_r[0] <= '0;
      total_r[1] <= '0;
      pend_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_JOINTS_LEFT:  jcl_r   <= cfg_data[3:0];
          CFG_JOINTS_RIGHT: jcr_r   <= cfg_data[3:0];
          CFG_WALK_SPEED:   speed_r <= cfg_data;
          default: ;
        endcase
      end

      if (key_in) begin
        if (in_data.last_of_key) begin
          pend_r    <= '0;
          res_r     <= '{kind: (key_ok ? KIND_ACCEPT : KIND_REJECT),
                         out_side: in_data.side, out_joint: 3'd0,
                         angle: 16'sd0, in_segment: 1'b0, last: 1'b1};
          out_valid <= 1'b1;
          if (key_ok) begin
            total_r[in_data.side] <= slot + TW'(1);
          end
        end else begin
          pend_r <= pend_inc;
        end
      end

      if (in_fire && in_data.opcode == OP_TICK) begin
        if ({1'b0, phase_r} + {1'b0, speed_r} >= 17'h10000) begin
          phase_r <= '0;
        end else begin
          phase_r <= phase_r + speed_r;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          side_r <= 1'b0;
        end
        ST_SIDE: begin
          ki_r    <= '0;
          found_r <= 1'b0;
          j_r     <= '0;
          if (nj_side == 5'd0) begin
            side_r <= 1'b1;
          end
        end
        ST_SCAN_A: ;
        ST_SCAN_B: ta_r <= t_rdata;
        ST_SCAN_C: begin
          if ({1'b0, phase_r} >= {1'b0, ta_r} && {1'b0, phase_r} < tb_w) begin
            found_r <= 1'b1;
            seg_r   <= ki_r[KW-1:0];
            nxt_r   <= last_key ? '0 : ki_next;
            dp_r    <= {1'b0, phase_r - ta_r};
            dt_r    <= tb_w - {1'b0, ta_r};
          end
          ki_r <= ki_r + TW'(1);
        end
        ST_JOINT: ;
        ST_RD_A: ;
        ST_RD_B: a_r <= {a_rdata[15], a_rdata};
        ST_MUL: begin
          diff_r <= $signed({a_rdata[15], a_rdata}) - a_r;
        end
        ST_DIV: begin
          if (bit_r == 6'd40) begin
            // magnitude product, then restoring division
            num_r <= PW'((diff_r[16] ? 17'(-diff_r) : diff_r) * dp_r);
            neg_r <= diff_r[16];
            rem_r <= '0;
            quo_r <= '0;
            bit_r <= 6'(PW);
          end else if (bit_r != 6'd0) begin
            rem_r <= rem_ge ? rem_sh - {1'b0, dt_r} : rem_sh;
            quo_r <= {quo_r[PW-2:0], rem_ge};
            num_r <= {num_r[PW-2:0], 1'b0};
            bit_r <= bit_r - 6'd1;
          end
        end
        ST_OUT: begin
          if (!out_valid) begin
            res_r     <= '{kind: KIND_ANGLE, out_side: side_r, out_joint: j_r[2:0],
                           angle: (found_r ? vsat : 16'sd0), in_segment: found_r,
                           last: (!more_joints && (side_r || clampj(jcr_r) == 5'd0))};
            out_valid <= 1'b1;
            j_r       <= j_r + 5'd1;
            if (!more_joints) begin
              side_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (state_r == ST_MUL) begin
        bit_r <= 6'd40;
      end
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cki_pkg::*;

  localparam int KEYS_PER_SIDE = 16;
  localparam int JOINTS_MAX    = 8;
  localparam int CYCLE_LIMIT   = 2000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  cyclic_keyframe_interpolator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [3:0]  pred_jcnt [2];
  logic [15:0] pred_speed;
  logic [15:0] pred_ktime [2][KEYS_PER_SIDE];
  logic [15:0] pred_kang [2][KEYS_PER_SIDE][JOINTS_MAX];
  int          pred_total [2];
  int          pred_phase;
  int          pred_pending;

  out_item_t   angle_queue[$];
  int          error_count;
  longint      cycle_count;

  // joint count at which each side's committed keys were loaded; a side is only
  // given more keys while its count stays the same, so no unwritten angle is read
  int pred_jcnt_fixed [2];
  function automatic bit ph_ok(int s);
    pred_jcnt_fixed[s] = joints_on(s);
    return 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int joints_on(int s);
    return (pred_jcnt[s] > JOINTS_MAX) ? JOINTS_MAX : int'(pred_jcnt[s]);
  endfunction

  function automatic out_item_t make_result(kind_t k, int s, int j, int a, int seg);
    out_item_t r;
    r.kind = k;
    r.out_side = s[0];
    r.out_joint = j[2:0];
    r.angle = a[15:0];
    r.in_segment = seg[0];
    r.last = 1'b0;
    return r;
  endfunction

  // interpolated angles of one side at the current phase
  task automatic predict_side(int s);
    int n, seg, nxt, dp, dt, ta, tb;
    bit found;
    longint a, b, v;
    n = joints_on(s);
    found = 0; seg = 0; nxt = 0; dp = 0; dt = 1;
    for (int i = 0; i < pred_total[s]; i++) begin
      ta = int'(pred_ktime[s][i]);
      tb = (i + 1 < pred_total[s]) ? int'(pred_ktime[s][i+1]) : 65536;
      if (pred_phase >= ta && pred_phase < tb) begin
        found = 1; seg = i;
        nxt = (i + 1 < pred_total[s]) ? i + 1 : 0;
        dp = pred_phase - ta; dt = tb - ta;
      end
    end
    for (int j = 0; j < n; j++) begin
      v = 0;
      if (found) begin
        a = longint'($signed(pred_kang[s][seg][j]));
        b = longint'($signed(pred_kang[s][nxt][j]));
        v = a + ((b - a) * dp) / dt;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      angle_queue.insert(angle_queue.size(),
                         make_result(KIND_ANGLE, s, j, int'(v), int'(found)));
    end
  endtask

  task automatic predict_item(in_item_t it);
    int s, slot, n_prior;
    s = int'(it.side);
    n_prior = angle_queue.size();
    case (opcode_t'(it.opcode))
      OP_KEY: begin
        slot = pred_total[s];
        if (slot < KEYS_PER_SIDE) begin
          pred_ktime[s][slot] = it.key_time;
          pred_kang[s][slot][it.joint_index] = it.key_angle;
        end
        if (pred_pending < 15) pred_pending++;
        if (it.last_of_key) begin
          if (slot < KEYS_PER_SIDE && pred_pending == joints_on(s)) begin
            pred_total[s] = slot + 1;
            angle_queue.insert(angle_queue.size(), make_result(KIND_ACCEPT, s, 0, 0, 0));
          end else begin
            angle_queue.insert(angle_queue.size(), make_result(KIND_REJECT, s, 0, 0, 0));
          end
          pred_pending = 0;
        end
      end
      OP_NONE: ;
      default: begin
        if (opcode_t'(it.opcode) == OP_TICK) begin
          pred_phase = pred_phase + int'(pred_speed);
          if (pred_phase >= 65536) pred_phase = 0;
        end
        predict_side(0);
        predict_side(1);
      end
    endcase
    if (angle_queue.size() > n_prior) angle_queue[$].last = 1'b1;
  endtask

  // result checking
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (angle_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        e = angle_queue.pop_front();
        if (out_data.kind !== e.kind)
          $display("%0t: kind exp %0d got %0d", $time, e.kind, out_data.kind);
        if (out_data.out_side !== e.out_side)
          $display("%0t: side exp %0d got %0d", $time, e.out_side, out_data.out_side);
        if (out_data.out_joint !== e.out_joint)
          $display("%0t: joint exp %0d got %0d", $time, e.out_joint, out_data.out_joint);
        if (out_data.angle !== e.angle)
          $display("%0t: angle exp %0d got %0d", $time, e.angle, out_data.angle);
        if (out_data.in_segment !== e.in_segment)
          $display("%0t: in_segment exp %0d got %0d", $time, e.in_segment,
                   out_data.in_segment);
        if (out_data.last !== e.last)
          $display("%0t: last exp %0d got %0d", $time, e.last, out_data.last);
        if (out_data !== e) error_count++;
      end
    end
  end

  // receiver stalls: mostly short, a few long, some stall-free stretches
  initial begin
    int r;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 60) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // idle the input for a while, or keep it busy for a back-to-back transfer
  task automatic sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    in_valid <= 1'b0;
    repeat ((r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
  endtask

  task automatic send_item(in_item_t it);
    sender_gap();
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_JOINTS_LEFT:  pred_jcnt[0] = value[3:0];
      CFG_JOINTS_RIGHT: pred_jcnt[1] = value[3:0];
      CFG_WALK_SPEED:   pred_speed = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic in_item_t mk(opcode_t op, int s, int t, int j, int a, int l);
    in_item_t it;
    it.opcode = op;
    it.side = s[0];
    it.key_time = t[15:0];
    it.joint_index = j[2:0];
    it.key_angle = a[15:0];
    it.last_of_key = l[0];
    return it;
  endfunction

  // one key with all configured joints, so committed angles are always written
  task automatic send_full_key(int s, int t);
    int n;
    n = joints_on(s);
    for (int j = 0; j < n; j++)
      send_item(mk(OP_KEY, s, t, j, $urandom_range(0, 65535), int'(j == n - 1)));
  endtask

  // directed table
  typedef struct {
    in_item_t  it;
    bit        has_exp;
    out_item_t exp_r;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    int s, t, n, r;

    error_count = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_JOINTS_LEFT;
    cfg_data = '0;
    pred_jcnt[0] = '0; pred_jcnt[1] = '0; pred_speed = '0;
    pred_total[0] = 0; pred_total[1] = 0;
    pred_phase = 0; pred_pending = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no joints yet, zero-count rejects, opcode 3 ignored
    row.has_exp = 1;
    row.it = mk(OP_KEY, 0, 0, 0, 100, 1);
    row.exp_r = make_result(KIND_REJECT, 0, 0, 0, 0); row.exp_r.last = 1;
    rows.insert(rows.size(), row);
    row.it = mk(OP_KEY, 1, 65535, 7, -32768, 1);
    row.exp_r = make_result(KIND_REJECT, 1, 0, 0, 0); row.exp_r.last = 1;
    rows.insert(rows.size(), row);
    row.has_exp = 0;
    row.it = mk(OP_NONE, 1, 65535, 7, 32767, 1); rows.insert(rows.size(), row);
    row.it = mk(OP_TICK, 0, 0, 0, 0, 0); rows.insert(rows.size(), row);
    row.it = mk(OP_QUERY, 0, 0, 0, 0, 0); rows.insert(rows.size(), row);
    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].has_exp && angle_queue[$] !== rows[i].exp_r) begin
        $display("%0t: table row %0d exp %h pred %h", $time, i, rows[i].exp_r,
                 angle_queue[$]);
        error_count++;
      end
    end
    drain();

    // extremes: 8 joints left, 15 (clamped) right, max speed
    write_reg(CFG_JOINTS_LEFT, 16'd8);
    write_reg(CFG_JOINTS_RIGHT, 16'd15);
    write_reg(CFG_WALK_SPEED, 16'hFFFF);
    rows.delete();
    row.has_exp = 0;
    for (int j = 0; j < 8; j++) begin
      row.it = mk(OP_KEY, 0, 0, j, (j[0]) ? 32767 : -32768, int'(j == 7));
      rows.insert(rows.size(), row);
    end
    for (int j = 0; j < 8; j++) begin
      row.it = mk(OP_KEY, 0, 40000, j, (j[0]) ? -32768 : 32767, int'(j == 7));
      rows.insert(rows.size(), row);
    end
    row.it = mk(OP_QUERY, 0, 0, 0, 0, 0); rows.insert(rows.size(), row);
    row.it = mk(OP_TICK, 0, 0, 0, 0, 0); rows.insert(rows.size(), row);
    row.it = mk(OP_TICK, 0, 0, 0, 0, 0); rows.insert(rows.size(), row);
    foreach (rows[i]) send_item(rows[i].it);
    // short key on right: rejected
    send_item(mk(OP_KEY, 1, 5, 3, 1, 1));
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_JOINTS_LEFT, 16'd0); write_reg(CFG_JOINTS_RIGHT, 16'd8); end
        1: begin write_reg(CFG_JOINTS_LEFT, 16'd1); write_reg(CFG_JOINTS_RIGHT, 16'd0); end
        default: begin
          write_reg(CFG_JOINTS_LEFT, 16'($urandom_range(1, 3)));
          write_reg(CFG_JOINTS_RIGHT, 16'($urandom_range(1, 3)));
        end
      endcase
      write_reg(CFG_WALK_SPEED, (ph == 5) ? 16'd0 : 16'($urandom_range(1, 20000)));
      for (s = 0; s < 2; s++) begin
        // keys keep needing full joint writes; only fill sides whose
        // committed keys already cover the current count
        for (int k = 0; k < 40; k++) begin
          r = $urandom_range(0, 99);
          n = joints_on(s);
          if (n == 0) break;
          t = (r < 80) ? $urandom_range(0, 65535) : ((r < 90) ? 0 : 65535);
          if (pred_total[s] == 0 && ph_ok(s)) begin
            send_full_key(s, t);
          end else if (pred_total[s] > 0 && pred_jcnt_fixed[s] == n && k < 4) begin
            send_full_key(s, t);
          end
        end
      end
      for (int k = 0; k < 30; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) send_item(mk(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom));
        else if (r < 75) send_item(mk(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom));
        else if (r < 85) send_item(mk(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom));
        else begin
          // broken key: fewer elements, rejected (count mismatch), or table full
          s = $urandom_range(0, 1);
          n = joints_on(s);
          if (n > 1 || pred_total[s] >= KEYS_PER_SIDE)
            send_item(mk(OP_KEY, s, $urandom, 0, $urandom, 1));
        end
      end
      drain();
    end

    if (angle_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, angle_queue.size());
      error_count++;
    end
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
